>>> hw/rtl/mwo_pkg.sv
// Shared constants, types and sine quarter-wave table for the waveform oscillator.
`default_nettype none

package mwo_pkg;

   localparam int PHASE_W   = 32;
   localparam int STEP_W    = 31;
   localparam int SAMPLE_W  = 16;
   localparam int WAVE_W    = 3;
   localparam int AMP_W     = 15;
   localparam int GAIN_W    = 13;
   localparam int RAW_W     = 18;          // signed Q16, +-1.0
   localparam int GMAG_W    = 25;          // clamped magnitude, Q24
   localparam int PROD_W    = GMAG_W + AMP_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 15;
   localparam int SINE_ADDR_W = 10;
   localparam int QTR_W     = SINE_ADDR_W - 2;
   localparam int QTR_DEPTH = 1 << QTR_W;
   localparam int SINE_MAG_W = 17;

   localparam logic [CSR_IDX_W-1:0] REG_WAVEFORM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AMPLITUDE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_GAIN = 2'd2;

   localparam logic [WAVE_W-1:0] WAVE_NONE   = 3'd0;
   localparam logic [WAVE_W-1:0] WAVE_SQUARE = 3'd1;
   localparam logic [WAVE_W-1:0] WAVE_SAW    = 3'd2;
   localparam logic [WAVE_W-1:0] WAVE_TRI    = 3'd3;
   localparam logic [WAVE_W-1:0] WAVE_SINE   = 3'd4;

   localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd16384;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 13'd256;

   typedef struct packed {
      logic accept;
      logic gain_en;
      logic scale_en;
      logic out_load;
   } mwo_cmd_type;

   typedef logic [SINE_MAG_W-1:0] sine_rom_type [QTR_DEPTH];

   // sin(pi/2 * q / QTR_DEPTH) in Q16, Taylor series of order 11 in Q30
   function automatic logic [SINE_MAG_W-1:0] sine_quarter(input int unsigned q);
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      r  = 64'(q) << (30 - QTR_W);
      x  = (r * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      t  = 64'd1073741824;
      t  = 64'd1073741824 - ((t * x2) >> 30) / 64'd110;
      t  = 64'd1073741824 - ((t * x2) >> 30) / 64'd72;
      t  = 64'd1073741824 - ((t * x2) >> 30) / 64'd42;
      t  = 64'd1073741824 - ((t * x2) >> 30) / 64'd20;
      t  = 64'd1073741824 - ((t * x2) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      s  = (s + 64'd8192) >> 14;
      return s[SINE_MAG_W-1:0];
   endfunction

   function automatic sine_rom_type sine_rom_build();
      sine_rom_type rom;
      for (int i = 0; i < QTR_DEPTH; i++) begin
         rom[i] = sine_quarter(i);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = sine_rom_build();
   localparam logic [SINE_MAG_W-1:0] SINE_PEAK = sine_quarter(QTR_DEPTH);

endpackage

`default_nettype wire

>>> hw/rtl/mwo_ctrl.sv
// Sequencing controller: accept, gain, scale and output steps.
`default_nettype none

module mwo_ctrl import mwo_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  wire logic  rsp_tready,
   output mwo_cmd_type cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_GAIN  = 2'd1;
   localparam logic [1:0] S_SCALE = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_GAIN;
            end
         end
         S_GAIN: begin
            cmd.gain_en = 1'b1;
            state_in    = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale_en = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> hw/rtl/mwo_dp.sv
// Datapath: registers, phase accumulator, raw wave, gain clamp and amplitude scaling.
`default_nettype none

module mwo_dp import mwo_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mwo_cmd_type          cmd,
   input  wire logic [STEP_W-1:0]    phase_step,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data,
   output logic signed [SAMPLE_W-1:0] sample
);

   localparam logic signed [RAW_W-1:0] ONE_Q16 = 18'sd65536;
   localparam logic signed [RAW_W+GAIN_W:0] G_MAX = 32'sd16777216;
   localparam logic signed [RAW_W+GAIN_W:0] G_MIN = -32'sd16777216;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(40'd8388608);

   logic [WAVE_W-1:0]  waveform_ff, waveform_in;
   logic [AMP_W-1:0]   amplitude_ff, amplitude_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;

   logic signed [RAW_W-1:0] raw_ff, raw_in;
   logic                    active_ff, active_in;
   logic                    neg_ff, neg_in;
   logic [GMAG_W-1:0]       gmag_ff, gmag_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;

   logic                    wave_ok;
   logic [15:0]             p;
   logic [16:0]             tri_d;
   logic [RAW_W:0]          tri_n;
   logic [SINE_ADDR_W-1:0]  k;
   logic [QTR_W-1:0]        q;
   logic [SINE_MAG_W-1:0]   sine_mag;
   logic signed [RAW_W+GAIN_W:0] g;
   logic signed [RAW_W+GAIN_W:0] g_clamp;
   logic [PROD_W-1:0]       rounded;
   logic [SAMPLE_W-1:0]     mag_out;

   assign wave_ok = (waveform_ff == WAVE_SQUARE) || (waveform_ff == WAVE_SAW) ||
                    (waveform_ff == WAVE_TRI) || (waveform_ff == WAVE_SINE);
   assign p = phase_ff[PHASE_W-1 -: 16];
   assign k = phase_ff[PHASE_W-1 -: SINE_ADDR_W];

   // raw value from the phase before the update
   always_comb begin
      tri_d    = p[15] ? {2'b00, p[14:0]} : (17'd32768 - {1'b0, p});
      tri_n    = {tri_d, 2'b00} - (RAW_W+1)'(65536);
      q        = k[QTR_W] ? QTR_W'(-k[QTR_W-1:0]) : k[QTR_W-1:0];
      if (k[QTR_W] && (k[QTR_W-1:0] == '0)) begin
         sine_mag = SINE_PEAK;
      end else begin
         sine_mag = SINE_ROM[q];
      end
      case (waveform_ff)
         WAVE_SQUARE: raw_in = p[15] ? ONE_Q16 : -ONE_Q16;
         WAVE_SAW:    raw_in = RAW_W'($signed({~p[15], p[14:0], 1'b0}));
         WAVE_TRI:    raw_in = $signed(tri_n[RAW_W-1:0]);
         WAVE_SINE: begin
            if (k[SINE_ADDR_W-1]) begin
               raw_in = -$signed({1'b0, sine_mag});
            end else begin
               raw_in = $signed({1'b0, sine_mag});
            end
         end
         default:     raw_in = '0;
      endcase
   end

   // gain and clamp to +-1.0 in Q24
   always_comb begin
      g = raw_ff * $signed({1'b0, gain_ff});
      if (g > G_MAX) begin
         g_clamp = G_MAX;
      end else if (g < G_MIN) begin
         g_clamp = G_MIN;
      end else begin
         g_clamp = g;
      end
      neg_in  = g_clamp[RAW_W+GAIN_W];
      gmag_in = neg_in ? GMAG_W'(-g_clamp) : GMAG_W'(g_clamp);
   end

   assign prod_in = gmag_ff * amplitude_ff;

   // round half away from zero on the magnitude
   always_comb begin
      rounded = (prod_ff + ROUND_HALF) >> 24;
      mag_out = rounded[SAMPLE_W-1:0];
      if (!active_ff) begin
         sample_in = '0;
      end else if (neg_ff) begin
         sample_in = -$signed(mag_out);
      end else begin
         sample_in = $signed(mag_out);
      end
   end

   always_comb begin
      waveform_in  = waveform_ff;
      amplitude_in = amplitude_ff;
      gain_in      = gain_ff;
      phase_in     = phase_ff;
      active_in    = active_ff;
      if (cmd.accept) begin
         active_in = wave_ok;
         if (wave_ok) begin
            phase_in = phase_ff + {1'b0, phase_step};
         end
      end
      if (csr_we) begin
         unique case (csr_index)
            REG_WAVEFORM: begin
               if (csr_data[WAVE_W-1:0] != waveform_ff) begin
                  waveform_in = csr_data[WAVE_W-1:0];
                  phase_in    = '0;
               end
            end
            REG_AMPLITUDE:  amplitude_in = csr_data[AMP_W-1:0];
            REG_DRIVE_GAIN: gain_in = csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff  <= WAVE_NONE;
         amplitude_ff <= AMP_RESET;
         gain_ff      <= GAIN_RESET;
         phase_ff     <= '0;
         active_ff    <= 1'b0;
      end else begin
         waveform_ff  <= waveform_in;
         amplitude_ff <= amplitude_in;
         gain_ff      <= gain_in;
         phase_ff     <= phase_in;
         active_ff    <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         raw_ff <= raw_in;
      end
      if (cmd.gain_en) begin
         neg_ff  <= neg_in;
         gmag_ff <= gmag_in;
      end
      if (cmd.scale_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.out_load) begin
         sample_ff <= sample_in;
      end
   end

   assign sample = sample_ff;

endmodule

`default_nettype wire

>>> hw/rtl/multi_waveform_oscillator.sv
// Top level of the multi-waveform oscillator: controller plus datapath.
//
//   port group  dir  word contents
//   req_*       in   tdata[30:0] phase_step, [31] zero
//   rsp_*       out  tdata[15:0] sample (signed)
//   csr_*       in   csr_index: 0 waveform, 1 amplitude, 2 drive_gain; csr_data
//
// Each word passes through four steps: accept/raw lookup, gain multiply and clamp,
// amplitude multiply, output register load; the two chained multipliers sit in separate steps.
// A new word is taken once the previous one has moved to the output register.
// rsp_tready low holds the result and stalls the sequencer in its last step.
// Reset is synchronous: phase 0, waveform none, amplitude 16384, gain 1.0.
`default_nettype none

module multi_waveform_oscillator import mwo_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [31:0]          req_tdata,   // [30:0] phase_step, [31] zero
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [15:0]               rsp_tdata,   // [15:0] sample
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data
);

   mwo_cmd_type cmd;
   logic signed [SAMPLE_W-1:0] sample;

   assign csr_ready = 1'b1;

   mwo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mwo_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .phase_step (req_tdata[STEP_W-1:0]),
      .csr_we     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .sample     (sample)
   );

   assign rsp_tdata = sample;

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.gain_en, cmd.scale_en, cmd.out_load}))
      else $error("more than one sequencer step active");

   a_accept_gain: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (cmd.gain_en && !req_tready))
      else $error("accepted word did not enter the gain step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("output register loaded over a pending word");

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("loaded result not presented");

endmodule

`default_nettype wire

>>> tb/multi_waveform_oscillator_checker.sv
// Tracks the oscillator's channels, predicts every sample and compares it.
`default_nettype none

module multi_waveform_oscillator_checker import mwo_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tready,
   input  wire logic [31:0]          req_tdata,
   input  wire logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic [15:0]          rsp_tdata,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data,
   output int                        fail_count,
   output int                        samples_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SINE_POINTS = 1 << SINE_ADDR_W;
   localparam int UNIT_Q16 = 65536;
   localparam int HALF_CYCLE = 32768;
   localparam longint UNIT_Q24 = 64'sd16777216;
   localparam longint SAMPLE_PEAK = (64'sd1 << (SAMPLE_W - 1)) - 1;
   localparam longint unsigned UNIT_Q30 = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   int sine_level [SINE_POINTS];

   logic [WAVE_W-1:0]  wave_sel;
   logic [AMP_W-1:0]   amp_level;
   logic [GAIN_W-1:0]  gain_q8;
   logic [PHASE_W-1:0] phase_now;
   logic signed [SAMPLE_W-1:0] expected_samples [$];
   int words_in;
   int words_out;

   assign samples_pending = words_in - words_out;

   // sine at k / SINE_POINTS of a cycle, Q16, quarter-wave folded Taylor series in Q30
   function automatic int sine_point(input int unsigned k);
      longint unsigned u, quad, r, x, x2, t, s;
      u = 64'(k) << (32 - SINE_ADDR_W);
      quad = (u >> 30) & 64'd3;
      r = u & (UNIT_Q30 - 64'd1);
      if (quad[0]) begin
         r = UNIT_Q30 - r;
      end
      x = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t = UNIT_Q30;
      for (int j = 10; j >= 2; j -= 2) begin
         t = UNIT_Q30 - ((t * x2) >> 30) / 64'(j * (j + 1));
      end
      s = (x * t) >> 30;
      s = (s + 64'd8192) >> 14;
      return (quad >= 64'd2) ? -int'(s) : int'(s);
   endfunction

   function automatic int raw_level(input logic [WAVE_W-1:0] wave,
                                    input logic [PHASE_W-1:0] phase);
      int p;
      int d;
      p = int'(phase[PHASE_W-1 -: 16]);
      d = (p < HALF_CYCLE) ? HALF_CYCLE - p : p - HALF_CYCLE;
      case (wave)
         WAVE_SQUARE: return (p < HALF_CYCLE) ? -UNIT_Q16 : UNIT_Q16;
         WAVE_SAW:    return (p - HALF_CYCLE) * 2;
         WAVE_TRI:    return 4 * d - UNIT_Q16;
         default:     return sine_level[phase[PHASE_W-1 -: SINE_ADDR_W]];
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] scaled_sample(input int level);
      longint g;
      longint mag;
      logic neg;
      logic signed [SAMPLE_W-1:0] result;
      if (amp_level == '0) begin
         return '0;
      end
      g = longint'(level) * longint'(gain_q8);
      if (g > UNIT_Q24) begin
         g = UNIT_Q24;
      end
      if (g < -UNIT_Q24) begin
         g = -UNIT_Q24;
      end
      neg = g < 0;
      mag = neg ? -g : g;
      mag = (mag * longint'(amp_level) + UNIT_Q24 / 2) / UNIT_Q24;
      if (mag > SAMPLE_PEAK) begin
         mag = SAMPLE_PEAK;
      end
      result = SAMPLE_W'(neg ? -mag : mag);
      return result;
   endfunction

   initial begin
      for (int k = 0; k < SINE_POINTS; k++) begin
         sine_level[k] = sine_point(k);
      end
   end

   always @(posedge clock) begin
      logic [STEP_W-1:0] step;
      logic signed [SAMPLE_W-1:0] want;
      if (reset) begin
         wave_sel = WAVE_NONE;
         amp_level = AMP_RESET;
         gain_q8 = GAIN_RESET;
         phase_now = '0;
         expected_samples.delete();
         words_in <= 0;
         words_out <= 0;
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WAVEFORM: begin
                  if (csr_data[WAVE_W-1:0] != wave_sel) begin
                     wave_sel = csr_data[WAVE_W-1:0];
                     phase_now = '0;
                  end
               end
               REG_AMPLITUDE: amp_level = csr_data[AMP_W-1:0];
               REG_DRIVE_GAIN: gain_q8 = csr_data[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            step = req_tdata[STEP_W-1:0];
            if (wave_sel >= WAVE_SQUARE && wave_sel <= WAVE_SINE) begin
               expected_samples.push_back(scaled_sample(raw_level(wave_sel, phase_now)));
               phase_now = phase_now + {1'b0, step};
            end else begin
               expected_samples.push_back('0);
            end
            words_in <= words_in + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            words_out <= words_out + 1;
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected sample word, expected none, got %0d",
                        $time, $signed(rsp_tdata));
               fail_count <= fail_count + 1;
            end else begin
               want = expected_samples.pop_front();
               if (want !== rsp_tdata) begin
                  $display("%0t: sample mismatch, expected %0d, got %0d",
                           $time, want, $signed(rsp_tdata));
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> tb/multi_waveform_oscillator_test.sv
// Top of the oscillator testbench: clock, reset, stimulus, flow control and verdict.
`default_nettype none

module multi_waveform_oscillator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mwo_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int SEGMENTS = 12;
   localparam int SEGMENT_WORDS = 131;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam logic [STEP_W-1:0] STEP_MAX = '1;
   localparam logic [STEP_W-1:0] STEP_QUARTER = 31'h4000_0000;
   localparam logic [STEP_W-1:0] STEP_TABLE = 31'h0040_0000;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic hold_trigger = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_count = 0;
   int   quiet_cycles = 0;
   int   fail_count;
   int   samples_pending;

   multi_waveform_oscillator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   multi_waveform_oscillator_checker sample_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .samples_pending (samples_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // sample sink: random backpressure, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_count <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_count != 0) begin
         hold_count <= hold_count - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("multi_waveform_oscillator_test NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_step(input logic [STEP_W-1:0] step);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, step};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_samples();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (samples_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [STEP_W-1:0] random_step();
      case ($urandom_range(3))
         0: return STEP_W'($urandom());
         1: return STEP_W'($urandom_range(0, 1 << 20));
         2: return {9'($urandom_range(0, 511)), 22'd0};
         default: return STEP_MAX - STEP_W'($urandom_range(0, 1023));
      endcase
   endfunction

   task automatic configure_random();
      logic [WAVE_W-1:0] wave;
      logic [CSR_DAT_W-1:0] level;
      logic [CSR_DAT_W-1:0] gain;
      case ($urandom_range(9))
         0: wave = WAVE_NONE;
         1: wave = WAVE_W'($urandom_range(5, 7));
         default: wave = WAVE_W'($urandom_range(WAVE_SQUARE, WAVE_SINE));
      endcase
      case ($urandom_range(3))
         0: level = 15'h7FFF;
         1: level = 15'd1;
         default: level = CSR_DAT_W'($urandom());
      endcase
      case ($urandom_range(3))
         0: gain = CSR_DAT_W'(GAIN_RESET);
         1: gain = 15'd5120;
         2: gain = CSR_DAT_W'($urandom_range(256, 5120));
         default: gain = CSR_DAT_W'($urandom());
      endcase
      if ($urandom_range(9) < 7) begin
         write_reg(REG_WAVEFORM, {12'($urandom()), wave});
      end
      write_reg(REG_AMPLITUDE, level);
      write_reg(REG_DRIVE_GAIN, gain);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // silent after reset, phase held
      send_step(STEP_MAX);
      send_step('0);
      drain_samples();

      write_reg(REG_WAVEFORM, 15'(WAVE_SQUARE));
      write_reg(REG_AMPLITUDE, 15'h7FFF);
      write_reg(REG_DRIVE_GAIN, 15'(GAIN_RESET));
      repeat (4) send_step(STEP_QUARTER);
      drain_samples();

      write_reg(REG_WAVEFORM, 15'(WAVE_SAW));
      send_step('0);
      send_step(STEP_MAX);
      send_step(STEP_MAX);
      send_step(31'd1);
      drain_samples();

      // triangle driven hard into a one-unit clamp; upper data bits ignored
      write_reg(REG_WAVEFORM, {12'hFFF, WAVE_TRI});
      write_reg(REG_DRIVE_GAIN, 15'd5120);
      write_reg(REG_AMPLITUDE, 15'd1);
      repeat (3) send_step(STEP_QUARTER);
      drain_samples();

      write_reg(REG_WAVEFORM, 15'(WAVE_SINE));
      write_reg(REG_DRIVE_GAIN, 15'(GAIN_RESET));
      write_reg(REG_AMPLITUDE, 15'h7FFF);
      send_step(STEP_TABLE);
      send_step(STEP_TABLE);
      send_step(STEP_QUARTER - STEP_TABLE);
      send_step(STEP_QUARTER);
      drain_samples();

      // same waveform again keeps the phase; zero amplitude still advances it
      write_reg(REG_WAVEFORM, 15'(WAVE_SINE));
      write_reg(REG_AMPLITUDE, 15'd0);
      send_step(STEP_QUARTER);
      send_step(STEP_TABLE);
      drain_samples();

      write_reg(REG_AMPLITUDE, 15'h7FFF);
      write_reg(REG_DRIVE_GAIN, 15'h7FFF);
      send_step(STEP_QUARTER);
      send_step(STEP_TABLE);
      drain_samples();
      write_reg(REG_DRIVE_GAIN, 15'd0);
      send_step(STEP_QUARTER);
      drain_samples();
      write_reg(REG_DRIVE_GAIN, 15'd100);
      send_step(STEP_QUARTER);
      drain_samples();

      // unused waveform codes behave as none
      for (int w = 5; w <= 7; w++) begin
         write_reg(REG_WAVEFORM, 15'(w));
         send_step(STEP_QUARTER);
         drain_samples();
      end
      write_reg(REG_SPARE, 15'h7FFF);
      send_step(STEP_QUARTER);
      drain_samples();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 4)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 75;
            end
            1: begin
               send_idle_pct = 75;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         configure_random();
         for (int i = 0; i < SEGMENT_WORDS; i++) begin
            if ((seg == 2 || seg == 9) && i == 10) begin
               hold_trigger <= ~hold_trigger;
            end
            send_step(random_step());
         end
         drain_samples();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (samples_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("multi_waveform_oscillator_test OK");
      end else begin
         $display("multi_waveform_oscillator_test NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
